// ===== src/mld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mld_pkg;

    // Field widths of the streaming channels
    localparam int ELEM_W = 32;
    localparam int RES_W  = 48;
    localparam int ROW_W  = 10;

    // Default result format: fraction bits of the Q.24 result words
    localparam int FRAC_BITS_DEF = 24;

    // Row counter wraps on reaching this count
    localparam int MAX_BASIS = 1024;

    // Fraction bits of the stored exchange constants
    localparam int CONST_BITS = 40;

    // |Cx| and |(4/3)Cx| in Q.40, Cx = -1.5 * cbrt(3 / (4 pi))
    localparam logic [63:0] CX_Q40 = 64'd1023123867060;
    localparam logic [63:0] VX_Q40 = 64'd1364165156080;

    // Saturation limits of the 48-bit result words
    localparam logic [RES_W-1:0] POS48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [RES_W-1:0] NEG48 = 48'h8000_0000_0000;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_FUNC_MODE = 1'b0;

    // functional_mode codes
    localparam logic MODE_NONE = 1'b0;
    localparam logic MODE_LSDA = 1'b1;

endpackage

`default_nettype wire

// ===== src/mld_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Element stream: one density/overlap element pair per transfer
interface mld_element_if import mld_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] da_element;
    logic signed [ELEM_W-1:0] db_element;
    logic signed [ELEM_W-1:0] s_element;
    logic                     row_end;
    logic                     matrix_end;

    modport source (
        output valid, da_element, db_element, s_element, row_end, matrix_end,
        input  ready
    );
    modport sink (
        input  valid, da_element, db_element, s_element, row_end, matrix_end,
        output ready
    );
endinterface

// Result stream: one transfer per finished row
interface mld_result_if import mld_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [ROW_W-1:0] row_number;
    logic signed [RES_W-1:0] vxc_alpha;
    logic signed [RES_W-1:0] vxc_beta;
    logic signed [RES_W-1:0] energy_row;
    logic signed [RES_W-1:0] energy_total;
    logic signed [RES_W-1:0] trace_total;
    logic                    last_row;

    modport source (
        output valid, row_number, vxc_alpha, vxc_beta, energy_row, energy_total,
               trace_total, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_number, vxc_alpha, vxc_beta, energy_row, energy_total,
               trace_total, last_row,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/mulliken_lsda_exchange_diagonal.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Mulliken-population LSDA exchange, diagonal form. Density and overlap
// elements stream in one transfer at a time; each element's two products
// D*S (alpha, beta) go through one shared 33x33 signed multiplier and are
// added with saturation into the row's population accumulators, so no new
// element is taken until states S_MULA, S_MULB and S_ACCB have run.
// The element flagged row_end closes the row: populations are clamped at
// zero and, with functional_mode set to LSDA, the block works out the
// cube root of each spin density digit by digit (ROOT_N = (48+2*FRAC_BITS+2)/3
// steps per spin, 32 at the default format) and then runs seven wide products
// (potentials, rho^(4/3) terms, energy, trace terms) on the same multiplier.
// The result sits in an output register, so the next element is taken while
// it waits. Running energy and trace totals are reported with every row and
// clear after the row flagged matrix_end. functional_mode is written over the
// APB port at byte address 0 and should only change while the block is idle.
module mulliken_lsda_exchange_diagonal import mld_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    mld_element_if.sink             element,
    mld_result_if.source            result
);

    localparam int ROOT_N = (RES_W + 2*FRAC_BITS + 2) / 3;
    localparam int TW     = 3*ROOT_N;
    localparam int RW     = 2*ROOT_N + 5;
    localparam int CW     = $clog2(ROOT_N);
    localparam logic [CW-1:0] ROOT_LAST = CW'(ROOT_N - 1);
    localparam int SH_L = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
    localparam int SH_R = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
    localparam logic [127:0] HALF_LSB = 128'(1) << (CONST_BITS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MULA   = 4'd1;
    localparam logic [3:0] S_MULB   = 4'd2;
    localparam logic [3:0] S_ACCB   = 4'd3;
    localparam logic [3:0] S_POP    = 4'd4;
    localparam logic [3:0] S_RSTART = 4'd5;
    localparam logic [3:0] S_ROOT   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_MPOST  = 4'd8;
    localparam logic [3:0] S_FINAL  = 4'd9;

    localparam logic [2:0] OP_VA = 3'd0;
    localparam logic [2:0] OP_VB = 3'd1;
    localparam logic [2:0] OP_EA = 3'd2;
    localparam logic [2:0] OP_EB = 3'd3;
    localparam logic [2:0] OP_E  = 3'd4;
    localparam logic [2:0] OP_TA = 3'd5;
    localparam logic [2:0] OP_TB = 3'd6;

    // ---------------------------------------------------------------- helpers

    // Population to result format: clamp at zero, rescale, saturate
    function automatic logic [RES_W-1:0] pop_q(input logic [63:0] acc);
        logic [63:0] v;
        v = acc >> SH_R;
        if (acc[63] || acc == 64'd0)
            return '0;
        else if (v > (64'(POS48) >> SH_L))
            return POS48;
        else
            return RES_W'(v << SH_L);
    endfunction

    function automatic logic [RES_W-1:0] sat48(input logic [RES_W+1:0] v);
        if (v[RES_W+1:RES_W-1] == 3'b000 || v[RES_W+1:RES_W-1] == 3'b111)
            return v[RES_W-1:0];
        else if (v[RES_W+1])
            return NEG48;
        else
            return POS48;
    endfunction

    function automatic logic is_const_op(input logic [2:0] op);
        return op inside {OP_VA, OP_VB, OP_E};
    endfunction

    // ---------------------------------------------------------------- state

    logic [3:0]         state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [63:0]        acc_a_reg, acc_a_next;
    logic [63:0]        acc_b_reg, acc_b_next;
    logic [RES_W-1:0]   energy_sum_reg, energy_sum_next;
    logic [RES_W-1:0]   trace_sum_reg, trace_sum_next;
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               spin_reg, spin_next;
    logic [CW-1:0]      root_cnt_reg, root_cnt_next;
    logic [2:0]         op_reg, op_next;
    logic [2:0]         mstep_reg, mstep_next;

    logic [ELEM_W-1:0]  da_reg, da_next;
    logic [ELEM_W-1:0]  db_reg, db_next;
    logic [ELEM_W-1:0]  s_reg, s_next;
    logic               row_end_reg, row_end_next;
    logic               mat_end_reg, mat_end_next;
    logic [63:0]        prod_reg, prod_next;
    logic [RES_W-1:0]   rho_a_reg, rho_a_next;
    logic [RES_W-1:0]   rho_b_reg, rho_b_next;
    logic [TW-1:0]      tr_reg, tr_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [ROOT_N-1:0]  y_reg, y_next;
    logic [2*ROOT_N-1:0] sq_reg, sq_next;
    logic [ROOT_N-1:0]  ya_reg, ya_next;
    logic [ROOT_N-1:0]  yb_reg, yb_next;
    logic [127:0]       macc_reg, macc_next;
    logic [RES_W-1:0]   va_mag_reg, va_mag_next;
    logic [RES_W-1:0]   vb_mag_reg, vb_mag_next;
    logic [RES_W-1:0]   e_mag_reg, e_mag_next;
    logic [RES_W-1:0]   ta_mag_reg, ta_mag_next;
    logic [RES_W-1:0]   tb_mag_reg, tb_mag_next;
    logic [RES_W:0]     e43_reg, e43_next;

    logic [ROW_W-1:0]   row_number_reg, row_number_next;
    logic [RES_W-1:0]   vxc_alpha_reg, vxc_alpha_next;
    logic [RES_W-1:0]   vxc_beta_reg, vxc_beta_next;
    logic [RES_W-1:0]   energy_row_reg, energy_row_next;
    logic [RES_W-1:0]   energy_total_reg, energy_total_next;
    logic [RES_W-1:0]   trace_total_reg, trace_total_next;
    logic               last_row_reg, last_row_next;

    // ---------------------------------------------------------------- datapath

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        op_a, op_b;
    logic [63:0]        acc_sel, acc_term;
    logic [64:0]        acc_sum;
    logic [63:0]        acc_sat;
    logic [RW-1:0]      r_sh, b_val, y_w, sq_w;
    logic               take;
    logic [ROOT_N-1:0]  y_new;
    logic [2*ROOT_N-1:0] sq4, y4;
    logic [2:0]         pstep;
    logic [127:0]       part;
    logic [127:0]       q_val;
    logic [RES_W-1:0]   q_lim, q_mag;
    logic [RES_W-1:0]   energy_new, trace_new;
    logic [16:0]        row_inc;
    logic               out_free;
    logic               cfg_wr;

    assign mul_p = mul_a * mul_b;

    // Shared population accumulate: product floored by 2^28, saturating add
    assign acc_sel  = (state_reg == S_ACCB) ? acc_b_reg : acc_a_reg;
    assign acc_term = $signed(prod_reg) >>> 28;
    assign acc_sum  = {acc_sel[63], acc_sel} + {acc_term[63], acc_term};
    assign acc_sat  = (acc_sum[64] == acc_sum[63]) ? acc_sum[63:0]
                    : (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    // Cube root step: three radicand bits in, one root bit out.
    // sq_reg tracks y^2 so the trial value 3(2y)^2 + 3(2y) + 1 needs adds only.
    assign y_w   = RW'(y_reg);
    assign sq_w  = RW'(sq_reg);
    assign r_sh  = {rem_reg[RW-4:0], tr_reg[TW-1 -: 3]};
    assign b_val = (sq_w << 3) + (sq_w << 2) + (y_w << 2) + (y_w << 1) + RW'(1);
    assign take  = (r_sh >= b_val);
    assign y_new = {y_reg[ROOT_N-2:0], take};
    assign sq4   = {sq_reg[2*ROOT_N-3:0], 2'b00};
    assign y4    = (2*ROOT_N)'(y_reg) << 2;

    // Wide multiply operands, picked by operation
    always_comb
    begin
        case (op_reg)
            OP_VA:   begin op_a = 64'(ya_reg);    op_b = VX_Q40;            end
            OP_VB:   begin op_a = 64'(yb_reg);    op_b = VX_Q40;            end
            OP_EA:   begin op_a = 64'(rho_a_reg); op_b = 64'(ya_reg);       end
            OP_EB:   begin op_a = 64'(rho_b_reg); op_b = 64'(yb_reg);       end
            OP_E:    begin op_a = 64'(e43_reg);   op_b = CX_Q40;            end
            OP_TA:   begin op_a = 64'(rho_a_reg); op_b = 64'(va_mag_reg);   end
            OP_TB:   begin op_a = 64'(rho_b_reg); op_b = 64'(vb_mag_reg);   end
            default: begin op_a = '0;             op_b = '0;                end
        endcase
    end

    // Partial product from the previous step, placed at its weight
    assign pstep = mstep_reg - 3'd1;
    always_comb
    begin
        case (pstep[1:0])
            2'd0:    part = {64'd0, prod_reg};
            2'd1,
            2'd2:    part = {32'd0, prod_reg, 32'd0};
            default: part = {prod_reg, 64'd0};
        endcase
    end

    // Post-scaling of a finished wide product
    assign q_val = is_const_op(op_reg) ? (macc_reg >> CONST_BITS) : (macc_reg >> FRAC_BITS);
    assign q_lim = (op_reg == OP_EA || op_reg == OP_EB) ? POS48 : NEG48;
    assign q_mag = (q_val > 128'(q_lim)) ? q_lim : q_val[RES_W-1:0];

    assign energy_new = sat48({{2{energy_sum_reg[RES_W-1]}}, energy_sum_reg}
                              - {2'b00, e_mag_reg});
    assign trace_new  = sat48({{2{trace_sum_reg[RES_W-1]}}, trace_sum_reg}
                              - {2'b00, ta_mag_reg} - {2'b00, tb_mag_reg});
    assign row_inc    = 17'(row_cnt_reg) + 17'd1;

    assign out_free = !out_valid_reg || result.ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // ---------------------------------------------------------------- control

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        acc_a_next        = acc_a_reg;
        acc_b_next        = acc_b_reg;
        energy_sum_next   = energy_sum_reg;
        trace_sum_next    = trace_sum_reg;
        row_cnt_next      = row_cnt_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        spin_next         = spin_reg;
        root_cnt_next     = root_cnt_reg;
        op_next           = op_reg;
        mstep_next        = mstep_reg;
        da_next           = da_reg;
        db_next           = db_reg;
        s_next            = s_reg;
        row_end_next      = row_end_reg;
        mat_end_next      = mat_end_reg;
        prod_next         = mul_p[63:0];
        rho_a_next        = rho_a_reg;
        rho_b_next        = rho_b_reg;
        tr_next           = tr_reg;
        rem_next          = rem_reg;
        y_next            = y_reg;
        sq_next           = sq_reg;
        ya_next           = ya_reg;
        yb_next           = yb_reg;
        macc_next         = macc_reg;
        va_mag_next       = va_mag_reg;
        vb_mag_next       = vb_mag_reg;
        e_mag_next        = e_mag_reg;
        ta_mag_next       = ta_mag_reg;
        tb_mag_next       = tb_mag_reg;
        e43_next          = e43_reg;
        row_number_next   = row_number_reg;
        vxc_alpha_next    = vxc_alpha_reg;
        vxc_beta_next     = vxc_beta_reg;
        energy_row_next   = energy_row_reg;
        energy_total_next = energy_total_reg;
        trace_total_next  = trace_total_reg;
        last_row_next     = last_row_reg;

        mul_a = {da_reg[ELEM_W-1], da_reg};
        mul_b = {s_reg[ELEM_W-1], s_reg};

        if (cfg_wr && paddr[PADDR_W-1:2] == REG_FUNC_MODE)
            mode_next = pwdata[0];

        case (state_reg)
            S_IDLE:
            begin
                if (element.valid)
                begin
                    da_next      = element.da_element;
                    db_next      = element.db_element;
                    s_next       = element.s_element;
                    row_end_next = element.row_end;
                    mat_end_next = element.matrix_end;
                    state_next   = S_MULA;
                end
            end

            S_MULA:
            begin
                state_next = S_MULB;
            end

            S_MULB:
            begin
                mul_a      = {db_reg[ELEM_W-1], db_reg};
                acc_a_next = acc_sat;
                state_next = S_ACCB;
            end

            S_ACCB:
            begin
                acc_b_next = acc_sat;
                state_next = row_end_reg ? S_POP : S_IDLE;
            end

            S_POP:
            begin
                rho_a_next = pop_q(acc_a_reg);
                rho_b_next = pop_q(acc_b_reg);
                acc_a_next = '0;
                acc_b_next = '0;
                spin_next  = 1'b0;
                if (mode_reg == MODE_LSDA)
                    state_next = S_RSTART;
                else
                begin
                    va_mag_next = '0;
                    vb_mag_next = '0;
                    e_mag_next  = '0;
                    ta_mag_next = '0;
                    tb_mag_next = '0;
                    state_next  = S_FINAL;
                end
            end

            S_RSTART:
            begin
                tr_next       = TW'(spin_reg ? rho_b_reg : rho_a_reg) << (2*FRAC_BITS);
                rem_next      = '0;
                y_next        = '0;
                sq_next       = '0;
                root_cnt_next = '0;
                state_next    = S_ROOT;
            end

            S_ROOT:
            begin
                tr_next       = tr_reg << 3;
                rem_next      = take ? (r_sh - b_val) : r_sh;
                y_next        = y_new;
                sq_next       = take ? (sq4 + y4 + (2*ROOT_N)'(1)) : sq4;
                root_cnt_next = root_cnt_reg + CW'(1);
                if (root_cnt_reg == ROOT_LAST)
                begin
                    if (!spin_reg)
                    begin
                        ya_next    = y_new;
                        spin_next  = 1'b1;
                        state_next = S_RSTART;
                    end
                    else
                    begin
                        yb_next    = y_new;
                        op_next    = OP_VA;
                        mstep_next = '0;
                        macc_next  = HALF_LSB;
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                // 64x64 as four 32x32 partial products, one per cycle
                mul_a = {1'b0, mstep_reg[1] ? op_a[63:32] : op_a[31:0]};
                mul_b = {1'b0, mstep_reg[0] ? op_b[63:32] : op_b[31:0]};
                if (mstep_reg != 3'd0)
                    macc_next = macc_reg + part;
                if (mstep_reg == 3'd4)
                    state_next = S_MPOST;
                else
                    mstep_next = mstep_reg + 3'd1;
            end

            S_MPOST:
            begin
                case (op_reg)
                    OP_VA:   va_mag_next = q_mag;
                    OP_VB:   vb_mag_next = q_mag;
                    OP_EA:   e43_next    = {1'b0, q_mag};
                    OP_EB:   e43_next    = e43_reg + {1'b0, q_mag};
                    OP_E:    e_mag_next  = q_mag;
                    OP_TA:   ta_mag_next = q_mag;
                    default: tb_mag_next = q_mag;
                endcase
                mstep_next = '0;
                op_next    = op_reg + 3'd1;
                macc_next  = is_const_op(op_reg + 3'd1) ? HALF_LSB : '0;
                state_next = (op_reg == OP_TB) ? S_FINAL : S_MUL;
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    row_number_next   = row_cnt_reg;
                    vxc_alpha_next    = RES_W'(0) - va_mag_reg;
                    vxc_beta_next     = RES_W'(0) - vb_mag_reg;
                    energy_row_next   = RES_W'(0) - e_mag_reg;
                    energy_total_next = energy_new;
                    trace_total_next  = trace_new;
                    last_row_next     = mat_end_reg;
                    if (mat_end_reg)
                    begin
                        energy_sum_next = '0;
                        trace_sum_next  = '0;
                        row_cnt_next    = '0;
                    end
                    else
                    begin
                        energy_sum_next = energy_new;
                        trace_sum_next  = trace_new;
                        row_cnt_next    = (row_inc >= 17'(MAX_BASIS)) ? '0 : row_inc[ROW_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_NONE;
            acc_a_reg      <= '0;
            acc_b_reg      <= '0;
            energy_sum_reg <= '0;
            trace_sum_reg  <= '0;
            row_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            spin_reg       <= 1'b0;
            root_cnt_reg   <= '0;
            op_reg         <= OP_VA;
            mstep_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            acc_a_reg      <= acc_a_next;
            acc_b_reg      <= acc_b_next;
            energy_sum_reg <= energy_sum_next;
            trace_sum_reg  <= trace_sum_next;
            row_cnt_reg    <= row_cnt_next;
            out_valid_reg  <= out_valid_next;
            spin_reg       <= spin_next;
            root_cnt_reg   <= root_cnt_next;
            op_reg         <= op_next;
            mstep_reg      <= mstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        da_reg           <= da_next;
        db_reg           <= db_next;
        s_reg            <= s_next;
        row_end_reg      <= row_end_next;
        mat_end_reg      <= mat_end_next;
        prod_reg         <= prod_next;
        rho_a_reg        <= rho_a_next;
        rho_b_reg        <= rho_b_next;
        tr_reg           <= tr_next;
        rem_reg          <= rem_next;
        y_reg            <= y_next;
        sq_reg           <= sq_next;
        ya_reg           <= ya_next;
        yb_reg           <= yb_next;
        macc_reg         <= macc_next;
        va_mag_reg       <= va_mag_next;
        vb_mag_reg       <= vb_mag_next;
        e_mag_reg        <= e_mag_next;
        ta_mag_reg       <= ta_mag_next;
        tb_mag_reg       <= tb_mag_next;
        e43_reg          <= e43_next;
        row_number_reg   <= row_number_next;
        vxc_alpha_reg    <= vxc_alpha_next;
        vxc_beta_reg     <= vxc_beta_next;
        energy_row_reg   <= energy_row_next;
        energy_total_reg <= energy_total_next;
        trace_total_reg  <= trace_total_next;
        last_row_reg     <= last_row_next;
    end

    // ---------------------------------------------------------------- ports

    assign element.ready = (state_reg == S_IDLE);

    assign result.valid        = out_valid_reg;
    assign result.row_number   = row_number_reg;
    assign result.vxc_alpha    = vxc_alpha_reg;
    assign result.vxc_beta     = vxc_beta_reg;
    assign result.energy_row   = energy_row_reg;
    assign result.energy_total = energy_total_reg;
    assign result.trace_total  = trace_total_reg;
    assign result.last_row     = last_row_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_FUNC_MODE) ? PDATA_W'(mode_reg) : '0;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mld_pkg::*;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN  = 32'sh8000_0000;
    localparam logic signed [ELEM_W-1:0] ONE_Q28   = 32'sh1000_0000;
    localparam logic signed [63:0]       TOTAL_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0]       TOTAL_LO  = 64'shFFFF_8000_0000_0000;
    localparam logic signed [63:0]       ACC_HI    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]       ACC_LO    = 64'sh8000_0000_0000_0000;
    localparam logic [127:0]             MAG_LIMIT = 128'h8000_0000_0000;
    localparam int                       TAIL_CYCLES = 150;

    typedef struct {
        logic [ROW_W-1:0] row_number;
        logic [RES_W-1:0] vxc_alpha;
        logic [RES_W-1:0] vxc_beta;
        logic [RES_W-1:0] energy_row;
        logic [RES_W-1:0] energy_total;
        logic [RES_W-1:0] trace_total;
        logic             last_row;
    } row_result_t;

    class exchange_row_checker;
        logic                mode;
        logic signed [63:0]  alpha_pop;
        logic signed [63:0]  beta_pop;
        logic signed [63:0]  energy_run;
        logic signed [63:0]  trace_run;
        logic [ROW_W-1:0]    row_idx;
        row_result_t         pending_rows[$];
        int                  mismatches;

        function new();
            mode       = MODE_NONE;
            alpha_pop  = '0;
            beta_pop   = '0;
            energy_run = '0;
            trace_run  = '0;
            row_idx    = '0;
            mismatches = 0;
        endfunction

        // D*S in Q.56, floored to Q.28, added with 64-bit saturation
        function logic signed [63:0] acc_add(logic signed [63:0] acc,
                                             logic signed [ELEM_W-1:0] d,
                                             logic signed [ELEM_W-1:0] s);
            logic signed [63:0] dw;
            logic signed [63:0] sw;
            logic signed [63:0] prod;
            logic signed [64:0] sum;
            dw   = d;
            sw   = s;
            prod = (dw * sw) >>> 28;
            sum  = prod + acc;
            if (sum[64] != sum[63])
                return sum[64] ? ACC_LO : ACC_HI;
            return sum[63:0];
        endfunction

        function logic [RES_W-1:0] density_q(logic signed [63:0] acc);
            logic [63:0] u;
            if (acc <= 0)
                return '0;
            u = acc >> (28 - FRAC_BITS_DEF);
            if (u > 64'(POS48))
                return POS48;
            return u[RES_W-1:0];
        endfunction

        // floor(cbrt(rho * 2^48)), result stays below 2^32
        function logic [31:0] cube_root(logic [RES_W-1:0] rho);
            logic [127:0] t;
            logic [127:0] c3;
            logic [31:0]  y;
            logic [31:0]  c;
            int           b;
            t = 128'(rho) << (2 * FRAC_BITS_DEF);
            y = '0;
            for (b = 31; b >= 0; b--)
            begin
                c  = y | (32'd1 << b);
                c3 = 128'(c) * 128'(c) * 128'(c);
                if (c3 <= t)
                    y = c;
            end
            return y;
        endfunction

        function logic signed [63:0] neg_scaled(logic [63:0] x, logic [63:0] k);
            logic [127:0] p;
            logic [63:0]  mag;
            p = (128'(x) * 128'(k) + (128'd1 << (CONST_BITS - 1))) >> CONST_BITS;
            if (p > MAG_LIMIT)
                p = MAG_LIMIT;
            mag = p[63:0];
            return -$signed(mag);
        endfunction

        function logic [63:0] rho_43(logic [RES_W-1:0] rho, logic [31:0] root);
            logic [127:0] p;
            p = (128'(rho) * 128'(root)) >> FRAC_BITS_DEF;
            if (p > 128'(POS48))
                p = 128'(POS48);
            return p[63:0];
        endfunction

        function logic signed [63:0] trace_part(logic [RES_W-1:0] rho,
                                                logic signed [63:0] v);
            logic [63:0]  mag;
            logic [127:0] p;
            mag = -v;
            p   = (128'(rho) * 128'(mag)) >> FRAC_BITS_DEF;
            if (p > MAG_LIMIT)
                p = MAG_LIMIT;
            mag = p[63:0];
            return -$signed(mag);
        endfunction

        function logic signed [63:0] sat48(logic signed [63:0] v);
            if (v > TOTAL_HI)
                return TOTAL_HI;
            if (v < TOTAL_LO)
                return TOTAL_LO;
            return v;
        endfunction

        function void take_element(logic signed [ELEM_W-1:0] da,
                                   logic signed [ELEM_W-1:0] db,
                                   logic signed [ELEM_W-1:0] s,
                                   logic row_end, logic matrix_end);
            logic [RES_W-1:0]   ra;
            logic [RES_W-1:0]   rb;
            logic [31:0]        ya;
            logic [31:0]        yb;
            logic signed [63:0] va;
            logic signed [63:0] vb;
            logic signed [63:0] e;
            row_result_t        r;
            alpha_pop = acc_add(alpha_pop, da, s);
            beta_pop  = acc_add(beta_pop, db, s);
            if (!row_end)
                return;
            ra        = density_q(alpha_pop);
            rb        = density_q(beta_pop);
            alpha_pop = '0;
            beta_pop  = '0;
            va = '0;
            vb = '0;
            e  = '0;
            if (mode == MODE_LSDA)
            begin
                ya = cube_root(ra);
                yb = cube_root(rb);
                va = neg_scaled(64'(ya), VX_Q40);
                vb = neg_scaled(64'(yb), VX_Q40);
                e  = neg_scaled(rho_43(ra, ya) + rho_43(rb, yb), CX_Q40);
                energy_run = sat48(energy_run + e);
                trace_run  = sat48(trace_run + trace_part(ra, va) + trace_part(rb, vb));
            end
            r.row_number   = row_idx;
            r.vxc_alpha    = va[RES_W-1:0];
            r.vxc_beta     = vb[RES_W-1:0];
            r.energy_row   = e[RES_W-1:0];
            r.energy_total = energy_run[RES_W-1:0];
            r.trace_total  = trace_run[RES_W-1:0];
            r.last_row     = matrix_end;
            pending_rows.push_back(r);
            if (matrix_end)
            begin
                energy_run = '0;
                trace_run  = '0;
                row_idx    = '0;
            end
            else if (int'(row_idx) + 1 >= MAX_BASIS)
                row_idx = '0;
            else
                row_idx = row_idx + 1'b1;
        endfunction

        function void compare_field(string name, logic [RES_W-1:0] want,
                                    logic [RES_W-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_row(row_result_t got);
            row_result_t want;
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected row result: expected none, actual row %0d",
                         $time, got.row_number);
                return;
            end
            want = pending_rows.pop_front();
            compare_field("row_number", RES_W'(want.row_number), RES_W'(got.row_number));
            compare_field("vxc_alpha", want.vxc_alpha, got.vxc_alpha);
            compare_field("vxc_beta", want.vxc_beta, got.vxc_beta);
            compare_field("energy_row", want.energy_row, got.energy_row);
            compare_field("energy_total", want.energy_total, got.energy_total);
            compare_field("trace_total", want.trace_total, got.trace_total);
            compare_field("last_row", RES_W'(want.last_row), RES_W'(got.last_row));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    bit                 quiet;

    exchange_row_checker rows_chk;

    mld_element_if element();
    mld_result_if  result();

    mulliken_lsda_exchange_diagonal uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .element (element),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 11) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            result.ready <= 1'b1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : watch_results
        row_result_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got.row_number   = result.row_number;
            got.vxc_alpha    = result.vxc_alpha;
            got.vxc_beta     = result.vxc_beta;
            got.energy_row   = result.energy_row;
            got.energy_total = result.energy_total;
            got.trace_total  = result.trace_total;
            got.last_row     = result.last_row;
            rows_chk.check_row(got);
        end
    end

    task automatic write_mode(input logic value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FUNC_MODE, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(value))
        begin
            rows_chk.mismatches++;
            $display("%0t: functional_mode readback: expected %h, actual %h",
                     $time, PDATA_W'(value), prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        rows_chk.mode = value;
    endtask

    task automatic send_element(input logic signed [ELEM_W-1:0] da,
                                input logic signed [ELEM_W-1:0] db,
                                input logic signed [ELEM_W-1:0] s,
                                input logic row_end, input logic matrix_end);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            element.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        element.valid      <= 1'b1;
        element.da_element <= da;
        element.db_element <= db;
        element.s_element  <= s;
        element.row_end    <= row_end;
        element.matrix_end <= matrix_end;
        do @(posedge clk); while (!element.ready);
        rows_chk.take_element(da, db, s, row_end, matrix_end);
    endtask

    // stop sending and let every outstanding row come back
    task automatic drain_rows();
        @(negedge clk);
        element.valid <= 1'b0;
        while (rows_chk.pending_rows.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, (1 << 21) - 1)) - (1 << 20);
            2: return {1'b0, 31'($urandom)};
            default:
                case ($urandom_range(0, 4))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return '0;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
        endcase
    endfunction

    task automatic random_rows(input int count, input int multi_pct, input int end_pct);
        int n;
        int len;
        int style;
        for (n = 0; n < count; n++)
        begin
            len   = ($urandom_range(1, 100) <= multi_pct) ? $urandom_range(2, 8) : 1;
            style = $urandom_range(0, 3);
            repeat (len - 1)
                send_element(pick_value(style), pick_value(style), pick_value(style),
                             1'b0, $urandom_range(0, 7) == 0);
            send_element(pick_value(style), pick_value(style), pick_value(style),
                         1'b1, $urandom_range(1, 100) <= end_pct);
        end
    endtask

    initial
    begin
        rows_chk           = new();
        quiet              = 1'b0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        element.valid      = 1'b0;
        element.da_element = '0;
        element.db_element = '0;
        element.s_element  = '0;
        element.row_end    = 1'b0;
        element.matrix_end = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no exchange: zeros, totals still reported
        write_mode(MODE_NONE);
        send_element(ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b0, 1'b0);
        send_element(ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1, 1'b0);
        send_element(ONE_Q28, ONE_Q28, ONE_Q28, 1'b0, 1'b1);
        send_element(ONE_Q28, -ONE_Q28, ONE_Q28, 1'b1, 1'b1);
        drain_rows();

        write_mode(MODE_LSDA);
        send_element('0, '0, '0, 1'b1, 1'b0);
        send_element(-ONE_Q28, ONE_Q28, ONE_Q28, 1'b1, 1'b0);
        // tiny products: floor sends -1 below zero
        send_element(32'sd1, 32'sd1, 32'sd1, 1'b0, 1'b0);
        send_element(32'sd1, -32'sd1, 32'sd1, 1'b1, 1'b0);
        send_element(ELEM_MIN, ELEM_MAX, ELEM_MIN, 1'b1, 1'b0);
        send_element(ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b0, 1'b0);
        send_element(ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b0, 1'b0);
        send_element(ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1, 1'b0);
        // density 8.0, exact cube root
        send_element(32'sh2000_0000, 32'sh2000_0000, 32'sh4000_0000, 1'b1, 1'b0);
        send_element(ONE_Q28, ONE_Q28, ONE_Q28, 1'b0, 1'b1);
        send_element(ELEM_MAX, '0, ELEM_MAX, 1'b1, 1'b1);
        send_element(ONE_Q28, ONE_Q28, ELEM_MAX, 1'b1, 1'b0);

        // long run without matrix end so the row counter wraps
        random_rows(500, 3, 0);
        drain_rows();
        random_rows(530, 3, 0);
        drain_rows();

        write_mode(MODE_NONE);
        random_rows(30, 40, 10);
        drain_rows();

        write_mode(MODE_LSDA);
        random_rows(30, 40, 10);
        quiet = 1'b1;
        random_rows(20, 40, 10);

        drain_rows();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (rows_chk.mismatches == 0 && rows_chk.pending_rows.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/mld_pkg.sv
src/mld_if.sv
src/mulliken_lsda_exchange_diagonal.sv
tb/testbench.sv
